// ----- hdl/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// types and constants shared by the fraction reduction block
// ----------------------------------------------------------------------------
package rar_pkg;
    localparam int IN_WIDTH  = 32;
    localparam int DEN_WIDTH = IN_WIDTH - 1;
    localparam int W         = 64;
    localparam int RDEN_W    = 62;
    localparam int CNT_W     = 7;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_RSV = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_SIGN, S_GCD_CHK, S_GCD_DIV, S_GCD_UPD,
        S_QN_DIV, S_QD_DIV, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic sign;
        logic div_start;
        logic [1:0] div_sel;
        logic gcd_upd;
        logic qn_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic b_zero;
        logic div_done;
    } t_sts;

    localparam logic [1:0] DSEL_GCD = 2'd0;
    localparam logic [1:0] DSEL_QN  = 2'd1;
    localparam logic [1:0] DSEL_QD  = 2'd2;
endpackage

// ----- hdl/rar_if.sv -----
// ----------------------------------------------------------------------------
// rar_in_if / rar_out_if
// valid/ready channels carrying operand and result words
// ----------------------------------------------------------------------------
interface rar_in_if;
    import rar_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic signed [IN_WIDTH-1:0]  x_num;
    logic [DEN_WIDTH-1:0]        x_den;
    logic signed [IN_WIDTH-1:0]  y_num;
    logic [DEN_WIDTH-1:0]        y_den;
    modport source (output valid, opcode, x_num, x_den, y_num, y_den, input ready);
    modport sink   (input valid, opcode, x_num, x_den, y_num, y_den, output ready);
endinterface

interface rar_out_if;
    import rar_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [W-1:0]      res_num;
    logic [RDEN_W-1:0]        res_den;
    logic                     div_error;
    modport source (output valid, res_num, res_den, div_error, input ready);
    modport sink   (input valid, res_num, res_den, div_error, output ready);
endinterface

// ----- hdl/rar_divider.sv -----
// ----------------------------------------------------------------------------
// rar_divider
// 64-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rar_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [rar_pkg::W-1:0] i_dividend,
    input  logic [rar_pkg::W-1:0] i_divisor,
    output logic                 o_done,
    output logic [rar_pkg::W-1:0] o_quot,
    output logic [rar_pkg::W-1:0] o_rem
);
    import rar_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_q, n_q, r_r, n_r, r_d, n_d;
    logic [W:0]       w_sh, w_diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        w_sh   = {r_r, r_q[W-1]};
        w_diff = w_sh - {1'b0, r_d};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_r = w_diff[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = w_sh[W-1:0];
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ----- hdl/rar_datapath.sv -----
// ----------------------------------------------------------------------------
// rar_datapath
// products, sign handling, gcd registers and result register
// ----------------------------------------------------------------------------
module rar_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rar_pkg::t_cmd                  i_cmd,
    output rar_pkg::t_sts                  o_sts,
    input  logic [1:0]                     i_opcode,
    input  logic signed [rar_pkg::IN_WIDTH-1:0] i_x_num,
    input  logic [rar_pkg::DEN_WIDTH-1:0]  i_x_den,
    input  logic signed [rar_pkg::IN_WIDTH-1:0] i_y_num,
    input  logic [rar_pkg::DEN_WIDTH-1:0]  i_y_den,
    output logic signed [rar_pkg::W-1:0]   o_res_num,
    output logic [rar_pkg::RDEN_W-1:0]     o_res_den,
    output logic                           o_div_error
);
    import rar_pkg::*;

    t_opcode                    r_op;
    logic signed [IN_WIDTH-1:0] r_xn, r_yn;
    logic [DEN_WIDTH-1:0]       r_xd, r_yd;
    logic                       r_err;
    logic signed [W-1:0]        r_p0, r_p1, r_num, r_den;
    logic                       r_neg;
    logic [W-1:0]               r_nmag, r_dmag, r_a, r_b, r_qn;
    logic signed [W-1:0]        r_res_num;
    logic [RDEN_W-1:0]          r_res_den;
    logic                       r_res_err;

    logic [W-1:0]               w_dvd, w_dvs, w_quot, w_rem;
    logic                       w_done;
    logic signed [IN_WIDTH:0]   w_m0a, w_m0b, w_m1a, w_m1b, w_m2a, w_m2b;

    always_comb begin
        w_m0a = {r_xn[IN_WIDTH-1], r_xn};
        w_m1a = {r_yn[IN_WIDTH-1], r_yn};
        w_m1b = {2'b00, r_xd};
        w_m2a = {2'b00, r_xd};
        w_m2b = {2'b00, r_yd};
        case (r_op)
            OP_MUL:  w_m0b = {r_yn[IN_WIDTH-1], r_yn};
            default: w_m0b = {2'b00, r_yd};
        endcase
        if (r_op == OP_DIV) w_m2b = {r_yn[IN_WIDTH-1], r_yn};
    end

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_QN: begin w_dvd = r_nmag; w_dvs = r_a; end
            DSEL_QD: begin w_dvd = r_dmag; w_dvs = r_a; end
            default: begin w_dvd = r_a;    w_dvs = r_b; end
        endcase
    end

    rar_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_xn  <= i_x_num;
            r_xd  <= i_x_den;
            r_yn  <= i_y_num;
            r_yd  <= i_y_den;
            r_err <= (i_x_den == '0) || (i_y_den == '0) ||
                     (t_opcode'(i_opcode) == OP_DIV && i_y_num == '0);
        end
        if (i_cmd.mul) begin
            r_p0  <= W'(w_m0a * w_m0b);
            r_p1  <= W'(w_m1a * w_m1b);
            r_den <= W'(w_m2a * w_m2b);
        end
        if (i_cmd.sum) begin
            r_num <= (r_op == OP_MUL || r_op == OP_DIV) ? r_p0 : r_p0 + r_p1;
        end
        if (i_cmd.sign) begin
            r_neg  <= r_num[W-1] ^ r_den[W-1];
            r_nmag <= r_num[W-1] ? W'(-r_num) : W'(r_num);
            r_dmag <= r_den[W-1] ? W'(-r_den) : W'(r_den);
            r_a    <= r_num[W-1] ? W'(-r_num) : W'(r_num);
            r_b    <= r_den[W-1] ? W'(-r_den) : W'(r_den);
        end
        if (i_cmd.gcd_upd) begin
            r_a <= r_b;
            r_b <= w_rem;
        end
        if (i_cmd.qn_load) r_qn <= w_quot;
        if (i_cmd.out_load) begin
            if (r_err) begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_res_err <= 1'b1;
            end else begin
                r_res_num <= r_neg ? W'(-r_qn) : r_qn;
                r_res_den <= w_quot[RDEN_W-1:0];
                r_res_err <= 1'b0;
            end
        end
    end

    assign o_sts.err      = r_err;
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_done = w_done;
    assign o_res_num      = r_res_num;
    assign o_res_den      = r_res_den;
    assign o_div_error    = r_res_err;
endmodule

// ----- hdl/rar_ctrl.sv -----
// ----------------------------------------------------------------------------
// rar_ctrl
// sequencer for load, products, gcd loop, quotients and hand-off
// ----------------------------------------------------------------------------
module rar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rar_pkg::t_sts i_sts,
    output rar_pkg::t_cmd o_cmd
);
    import rar_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ovalid   = r_ovalid;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_sts.err ? S_OUT : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SIGN;
            end
            S_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = S_GCD_CHK;
            end
            S_GCD_CHK: begin
                if (i_sts.b_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_QN;
                    n_state         = S_QN_DIV;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_GCD;
                    n_state         = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                o_cmd.div_sel = DSEL_GCD;
                if (i_sts.div_done) n_state = S_GCD_UPD;
            end
            S_GCD_UPD: begin
                o_cmd.gcd_upd = 1'b1;
                n_state       = S_GCD_CHK;
            end
            S_QN_DIV: begin
                o_cmd.div_sel = DSEL_QN;
                if (i_sts.div_done) begin
                    o_cmd.qn_load   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_QD;
                    n_state         = S_QD_DIV;
                end
            end
            S_QD_DIV: begin
                o_cmd.div_sel = DSEL_QD;
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.div_sel = DSEL_QD;
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;
endmodule

// ----- hdl/rational_arith_reduce.sv -----
// ----------------------------------------------------------------------------
// rational_arith_reduce
// add, multiply or divide two fractions and reduce the result by its gcd
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_in     in   opcode, x_num, x_den, y_num, y_den
// m_out    out  res_num, res_den, div_error
//
// one word at a time; a shared divider runs once per euclid step plus twice
// for the quotients, between accept and result valid; error words go from
// S_MUL straight to S_OUT and skip the divider
// sync active-low reset, no state kept; a stalled output holds the block in S_OUT
// a result waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
module rational_arith_reduce (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rar_in_if.sink    s_in,
    rar_out_if.source m_out
);
    import rar_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rar_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (s_in.opcode),
        .i_x_num     (s_in.x_num),
        .i_x_den     (s_in.x_den),
        .i_y_num     (s_in.y_num),
        .i_y_den     (s_in.y_den),
        .o_res_num   (m_out.res_num),
        .o_res_den   (m_out.res_den),
        .o_div_error (m_out.div_error)
    );
endmodule

// ----- bench/rar_result_checker.sv -----
// ----------------------------------------------------------------------------
// rar_result_checker
// watches both channels, predicts each reduced fraction and compares it
// ----------------------------------------------------------------------------
module rar_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rar_in_if           s_in,
    rar_out_if          m_out,
    output int          o_err_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_flagged_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rar_pkg::*;

    typedef struct packed {
        logic signed [W-1:0]   num;
        logic [RDEN_W-1:0]     den;
        logic                  err;
    } t_fraction;

    t_fraction reduced_q[$];

    function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_fraction reduce_fraction(logic [1:0] op,
                                                  logic signed [IN_WIDTH-1:0] xn,
                                                  logic [DEN_WIDTH-1:0] xd,
                                                  logic signed [IN_WIDTH-1:0] yn,
                                                  logic [DEN_WIDTH-1:0] yd);
        t_fraction r;
        longint sxn, sxd, syn, syd, num, den;
        longint unsigned nmag, dmag, g, qn;
        logic neg;
        sxn = xn;
        syn = yn;
        sxd = {33'd0, xd};
        syd = {33'd0, yd};
        r = '0;
        if (xd == 0 || yd == 0 || (t_opcode'(op) == OP_DIV && yn == 0)) begin
            r.err = 1'b1;
            return r;
        end
        case (t_opcode'(op))
            OP_MUL: begin
                num = sxn * syn;
                den = sxd * syd;
            end
            OP_DIV: begin
                num = sxn * syd;
                den = sxd * syn;
            end
            default: begin
                num = sxn * syd + syn * sxd;
                den = sxd * syd;
            end
        endcase
        neg = num < 0;
        nmag = neg ? -num : num;
        if (den < 0) begin
            neg = !neg;
            dmag = -den;
        end else begin
            dmag = den;
        end
        g = euclid_gcd(nmag, dmag);
        qn = nmag / g;
        r.num = neg ? -qn : qn;
        r.den = RDEN_W'(dmag / g);
        return r;
    endfunction

    initial begin
        o_err_count = 0;
        o_result_count = 0;
        o_flagged_count = 0;
    end

    assign o_pending = reduced_q.size();

    always @(posedge i_clk) begin
        t_fraction exp_r;
        if (i_rst_n && s_in.valid && s_in.ready)
            reduced_q.push_back(reduce_fraction(s_in.opcode, s_in.x_num, s_in.x_den,
                                                s_in.y_num, s_in.y_den));
        if (i_rst_n && m_out.valid && m_out.ready) begin
            o_result_count++;
            if (m_out.div_error)
                o_flagged_count++;
            if (reduced_q.size() == 0) begin
                $error("unexpected result word num=%0d den=%0d err=%0b",
                       m_out.res_num, m_out.res_den, m_out.div_error);
                o_err_count++;
            end else begin
                exp_r = reduced_q.pop_front();
                if (m_out.res_num !== exp_r.num) begin
                    $error("res_num expected %0d actual %0d", exp_r.num, m_out.res_num);
                    o_err_count++;
                end
                if (m_out.res_den !== exp_r.den) begin
                    $error("res_den expected %0d actual %0d", exp_r.den, m_out.res_den);
                    o_err_count++;
                end
                if (m_out.div_error !== exp_r.err) begin
                    $error("div_error expected %0b actual %0b", exp_r.err,
                           m_out.div_error);
                    o_err_count++;
                end
            end
        end
    end
endmodule

// ----- bench/rational_arith_reduce_test.sv -----
// ----------------------------------------------------------------------------
// rational_arith_reduce_test
// directed and random fraction words with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module rational_arith_reduce_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rar_pkg::*;

    localparam int N_RANDOM = 630;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   err_count, pending, result_count, flagged_count;
    int   sent = 0;
    bit   no_gaps = 1'b0;

    rar_in_if  s_in();
    rar_out_if m_out();

    rational_arith_reduce u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    rar_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_in            (s_in),
        .m_out           (m_out),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_flagged_count (flagged_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        s_in.valid = 1'b0;
        s_in.opcode = '0;
        s_in.x_num = '0;
        s_in.x_den = '0;
        s_in.y_num = '0;
        s_in.y_den = '0;
        m_out.ready = 1'b0;
    end

    task automatic send_word(t_opcode op, logic signed [IN_WIDTH-1:0] xn,
                             logic [DEN_WIDTH-1:0] xd, logic signed [IN_WIDTH-1:0] yn,
                             logic [DEN_WIDTH-1:0] yd);
        int gap;
        s_in.valid  <= 1'b1;
        s_in.opcode <= op;
        s_in.x_num  <= xn;
        s_in.x_den  <= xd;
        s_in.y_num  <= yn;
        s_in.y_den  <= yd;
        do @(posedge i_clk); while (!(s_in.valid && s_in.ready));
        sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_word();
        t_opcode op;
        int sel;
        logic signed [IN_WIDTH-1:0] xn, yn;
        logic [DEN_WIDTH-1:0] xd, yd;
        sel = $urandom_range(0, 99);
        op = t_opcode'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
        if (sel < 45) begin
            xn = $signed($urandom_range(0, 200)) - 100;
            yn = $signed($urandom_range(0, 200)) - 100;
            xd = DEN_WIDTH'($urandom_range(1, 60));
            yd = DEN_WIDTH'($urandom_range(1, 60));
        end else if (sel < 88) begin
            xn = $urandom();
            yn = $urandom();
            xd = DEN_WIDTH'($urandom());
            yd = DEN_WIDTH'($urandom());
            if (xd == 0) xd = 1;
            if (yd == 0) yd = 1;
        end else begin
            xn = $urandom_range(0, 3) == 0 ? 0 : $urandom();
            yn = $urandom_range(0, 2) == 0 ? 0 : $urandom();
            xd = $urandom_range(0, 1) ? {DEN_WIDTH{1'b1}}
                                      : DEN_WIDTH'($urandom_range(0, 4));
            yd = $urandom_range(0, 1) ? {DEN_WIDTH{1'b1}}
                                      : DEN_WIDTH'($urandom_range(0, 4));
        end
        send_word(op, xn, xd, yn, yd);
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken == 120) begin
                m_out.ready <= 1'b0;
                repeat (15000) @(posedge i_clk);
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_out.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_out.ready <= 1'b1;
            do @(posedge i_clk); while (!(m_out.valid && m_out.ready));
            taken++;
        end
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d words still expected", pending);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_word(OP_ADD, 0, 1, 0, 1);
        send_word(OP_ADD, 1, 2, -1, 2);
        send_word(OP_ADD, 1, 3, 1, 6);
        send_word(OP_MUL, -6, 4, 10, 15);
        send_word(OP_DIV, 3, 4, -9, 8);
        send_word(OP_DIV, 5, 7, 0, 3);
        send_word(OP_DIV, -5, 7, -10, 14);
        send_word(OP_RSV, 2, 3, 5, 7);
        send_word(OP_ADD, 4, 0, 1, 1);
        send_word(OP_MUL, 4, 1, 1, 0);
        send_word(OP_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
        send_word(OP_MUL, 32'sh7fff_ffff, 31'h7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_word(OP_ADD, 32'sh8000_0000, 31'h7fff_ffff, 32'sh8000_0000, 31'h7fff_fffe);
        send_word(OP_ADD, 32'sh7fff_ffff, 31'h7fff_fffe, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_word(OP_DIV, 32'sh8000_0000, 31'h7fff_ffff, 32'sh8000_0000, 1);
        send_word(OP_DIV, 32'sh7fff_ffff, 1, 32'sh8000_0000, 31'h7fff_ffff);
        send_word(OP_DIV, 32'sh8000_0000, 1, -1, 1);
        send_word(OP_MUL, 0, 31'h7fff_ffff, 32'sh8000_0000, 1);
        send_word(OP_ADD, 7, 7, 14, 14);
        send_word(OP_DIV, 0, 5, 3, 5);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 50)
                no_gaps = 1'b1;
            else if (i % 100 == 80)
                no_gaps = 1'b0;
            send_random_word();
        end
        s_in.valid <= 1'b0;
        no_gaps = 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("sent %0d fraction words, checked %0d results", sent, result_count);
        $display("%0d results carried the error flag", flagged_count);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- rational_arith_reduce.f -----
hdl/rar_pkg.sv
hdl/rar_if.sv
hdl/rar_divider.sv
hdl/rar_datapath.sv
hdl/rar_ctrl.sv
hdl/rational_arith_reduce.sv
bench/rar_result_checker.sv
bench/rational_arith_reduce_test.sv
